### design/srlos_pkg.sv
`default_nettype none
package srlos_pkg;

   // field widths of the request words and of the CSR write
   localparam int COORD_W         = 16;
   localparam int SIZE_W          = 15;
   localparam int INDEX_W         = 4;
   localparam int CSR_W           = 5;
   localparam int COORD_FRAC_BITS = 4;

   // defaults for the top level parameters
   localparam int MAX_WALLS_DEF   = 16;
   localparam int T_FRAC_BITS_DEF = 16;

   // request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // one wall entry of the table
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
   } wall_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_AXIS,
      ST_WAIT_LO,
      ST_WAIT_HI,
      ST_CHECK,
      ST_NEXT,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic wr_wall;
      logic load_query;
      logic rd_wall;
      logic inc_idx;
      logic axis;
      logic edge_hi;
      logic div_start;
      logic save_t1;
      logic update;
      logic set_hit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic n_zero;
      logic last;
      logic delta_zero;
      logic in_slab;
      logic t_ok;
      logic div_busy;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

### design/srlos_if.sv
`default_nettype none
interface srlos_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  mode;
   logic [srlos_pkg::INDEX_W-1:0]         wall_index;
   logic signed [srlos_pkg::COORD_W-1:0]  rect_x;
   logic signed [srlos_pkg::COORD_W-1:0]  rect_y;
   logic [srlos_pkg::SIZE_W-1:0]          rect_w;
   logic [srlos_pkg::SIZE_W-1:0]          rect_h;
   logic signed [srlos_pkg::COORD_W-1:0]  start_x;
   logic signed [srlos_pkg::COORD_W-1:0]  start_y;
   logic signed [srlos_pkg::COORD_W-1:0]  end_x;
   logic signed [srlos_pkg::COORD_W-1:0]  end_y;

   modport source (output valid, mode, wall_index, rect_x, rect_y, rect_w, rect_h,
                   start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, mode, wall_index, rect_x, rect_y, rect_w, rect_h,
                   start_x, start_y, end_x, end_y, output ready);
endinterface

interface srlos_rsp_if;
   logic valid;
   logic ready;
   logic line_clear;

   modport source (output valid, line_clear, input ready);
   modport sink   (input valid, line_clear, output ready);
endinterface
`default_nettype wire

### design/segment_rect_line_of_sight_core.sv
`default_nettype none
// Line-of-sight tester over a table of axis-aligned walls.
// req_chan carries request words: mode write stores one wall (left, top,
// width, height) at wall_index and gives no response; mode query gives a
// segment and yields one rsp_chan word, line_clear = 1 when no wall in use
// crosses it. csr_we/csr_wdata set walls_in_use, the count of entries tested
// from entry 0 up (saturated at MAX_WALLS); write it only while idle.
// A write word is taken without leaving idle. A query tests each wall in
// turn with the single serial divider, which produces one quotient bit a
// cycle and is used for both edges of both axes. A wall found hit ends
// the walk early.
// One word is in work at a time: req_chan.ready is high only while idle, and
// the response waits in place while rsp_chan.ready is low.
// Reset clears walls_in_use to 0 and the controller to idle; the wall table
// is not cleared and must be written before a query tests an entry.
module segment_rect_line_of_sight_core #(
   parameter int MAX_WALLS   = srlos_pkg::MAX_WALLS_DEF,
   parameter int T_FRAC_BITS = srlos_pkg::T_FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   srlos_req_if.sink                            req_chan,
   srlos_rsp_if.source                          rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [srlos_pkg::CSR_W-1:0]     csr_wdata
);

   srlos_pkg::cmd_type    cmd;
   srlos_pkg::status_type status;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  line_clear;

   srlos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   srlos_datapath #(
      .MAX_WALLS   (MAX_WALLS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .wall_index (req_chan.wall_index),
      .rect_x     (req_chan.rect_x),
      .rect_y     (req_chan.rect_y),
      .rect_w     (req_chan.rect_w),
      .rect_h     (req_chan.rect_h),
      .start_x    (req_chan.start_x),
      .start_y    (req_chan.start_y),
      .end_x      (req_chan.end_x),
      .end_y      (req_chan.end_y),
      .line_clear (line_clear)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.line_clear = line_clear;

endmodule
`default_nettype wire

### design/srlos_div.sv
`default_nettype none
// Serial restoring divider, sign and magnitude, one quotient bit a cycle.
// Computes (numer << T_FRAC_BITS) / denom truncated toward zero.
module srlos_div #(
   parameter int T_FRAC_BITS = srlos_pkg::T_FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [17:0]              numer,
   input  wire logic signed [16:0]              denom,
   output logic                                 busy,
   output logic                                 done,
   output logic signed [T_FRAC_BITS+17:0]       quot
);

   localparam int QW = 17 + T_FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [15:0]       den_ff, den_in;
   logic [15:0]       rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [17:0]       num_mag;
   logic [16:0]       den_mag;
   logic [16:0]       trial;
   logic [16:0]       diff;
   logic              ge;

   // take magnitudes of the operands
   assign num_mag = numer[17] ? 18'(-numer) : 18'(numer);
   assign den_mag = denom[16] ? 17'(-denom) : 17'(denom);

   // one restoring step
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         neg_in  = numer[17] ^ denom[16];
         den_in  = den_mag[15:0];
         rem_in  = '0;
         quo_in  = {num_mag[16:0], {T_FRAC_BITS{1'b0}}};
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // apply the sign
   assign quot = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign busy = busy_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

### design/srlos_datapath.sv
`default_nettype none
module srlos_datapath #(
   parameter int MAX_WALLS   = srlos_pkg::MAX_WALLS_DEF,
   parameter int T_FRAC_BITS = srlos_pkg::T_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire srlos_pkg::cmd_type                   cmd,
   output srlos_pkg::status_type                     status,
   input  wire logic                                 csr_we,
   input  wire logic [srlos_pkg::CSR_W-1:0]          csr_wdata,
   input  wire logic [srlos_pkg::INDEX_W-1:0]        wall_index,
   input  wire logic signed [srlos_pkg::COORD_W-1:0] rect_x,
   input  wire logic signed [srlos_pkg::COORD_W-1:0] rect_y,
   input  wire logic [srlos_pkg::SIZE_W-1:0]         rect_w,
   input  wire logic [srlos_pkg::SIZE_W-1:0]         rect_h,
   input  wire logic signed [srlos_pkg::COORD_W-1:0] start_x,
   input  wire logic signed [srlos_pkg::COORD_W-1:0] start_y,
   input  wire logic signed [srlos_pkg::COORD_W-1:0] end_x,
   input  wire logic signed [srlos_pkg::COORD_W-1:0] end_y,
   output logic                                      line_clear
);

   localparam int IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   localparam int N_W   = $clog2(MAX_WALLS + 1);
   localparam int TW    = T_FRAC_BITS + 18;

   srlos_pkg::wall_type       wall_mem [MAX_WALLS];
   srlos_pkg::wall_type       wall_ff;
   logic [srlos_pkg::CSR_W-1:0] walls_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic signed [15:0]        sx_ff, sy_ff;
   logic signed [16:0]        dx_ff, dy_ff;
   logic signed [TW-1:0]      t1_ff, tmin_ff, tmax_ff;
   logic signed [TW-1:0]      tmin_in, tmax_in;
   logic                      clear_ff;
   logic [N_W-1:0]            n_eff;
   logic                      wr_ok;

   logic signed [16:0]        lo, hi, s, dlt;
   logic [14:0]               size;
   logic signed [17:0]        numer;
   logic signed [TW-1:0]      quot, ta, tb;
   logic                      div_busy, div_done;

   // store a wall word; entries beyond the table are dropped
   assign wr_ok = cmd.wr_wall && (32'(wall_index) < MAX_WALLS);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         wall_mem[IDX_W'(wall_index)] <= '{x: rect_x, y: rect_y, w: rect_w, h: rect_h};
      end
      if (cmd.rd_wall) begin
         wall_ff <= wall_mem[idx_ff];
      end
   end

   // wall count register
   always_ff @(posedge clock) begin
      if (reset) begin
         walls_ff <= '0;
      end else if (csr_we) begin
         walls_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (32'(walls_ff) > MAX_WALLS) begin
         n_eff = N_W'(MAX_WALLS);
      end else begin
         n_eff = N_W'(walls_ff);
      end
   end

   // hold the query and walk the table index
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         sx_ff <= start_x;
         sy_ff <= start_y;
         dx_ff <= {end_x[15], end_x} - {start_x[15], start_x};
         dy_ff <= {end_y[15], end_y} - {start_y[15], start_y};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         clear_ff <= 1'b1;
      end else begin
         if (cmd.load_query) begin
            idx_ff   <= '0;
            clear_ff <= 1'b1;
         end else if (cmd.inc_idx) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.set_hit) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // select the slab of the current axis
   always_comb begin
      if (cmd.axis) begin
         lo   = {wall_ff.y[15], wall_ff.y};
         size = wall_ff.h;
         s    = {sy_ff[15], sy_ff};
         dlt  = dy_ff;
      end else begin
         lo   = {wall_ff.x[15], wall_ff.x};
         size = wall_ff.w;
         s    = {sx_ff[15], sx_ff};
         dlt  = dx_ff;
      end
      hi = lo + $signed({2'b00, size});
      if (cmd.edge_hi) begin
         numer = {hi[16], hi} - {s[16], s};
      end else begin
         numer = {lo[16], lo} - {s[16], s};
      end
   end

   srlos_div #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (dlt),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   // order the two crossings and clip the interval
   always_comb begin
      if (t1_ff > quot) begin
         ta = quot;
         tb = t1_ff;
      end else begin
         ta = t1_ff;
         tb = quot;
      end
      tmin_in = (ta > tmin_ff) ? ta : tmin_ff;
      tmax_in = (tb < tmax_ff) ? tb : tmax_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.save_t1) begin
         t1_ff <= quot;
      end
      if (cmd.rd_wall) begin
         tmin_ff <= '0;
         tmax_ff <= $signed({{(TW-T_FRAC_BITS-1){1'b0}}, 1'b1, {T_FRAC_BITS{1'b0}}});
      end else if (cmd.update) begin
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
      end
   end

   assign status.n_zero     = (walls_ff == '0);
   assign status.last       = ((N_W'(idx_ff) + N_W'(1)) == n_eff);
   assign status.delta_zero = (dlt == '0);
   assign status.in_slab    = (s >= lo) && (s <= hi);
   assign status.t_ok       = (tmin_ff <= tmax_ff);
   assign status.div_busy   = div_busy;
   assign status.div_done   = div_done;
   assign line_clear        = clear_ff;

endmodule
`default_nettype wire

### design/srlos_ctrl.sv
`default_nettype none
module srlos_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_mode,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output srlos_pkg::cmd_type           cmd,
   input  wire srlos_pkg::status_type   status
);

   srlos_pkg::state_type state_ff, state_in;
   logic                 axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srlos_pkg::ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   // sequence walls, axes and the two divisions of each axis
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      cmd       = '0;
      cmd.axis  = axis_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         srlos_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == srlos_pkg::MODE_WRITE) begin
                  cmd.wr_wall = 1'b1;
               end else begin
                  cmd.load_query = 1'b1;
                  state_in = status.n_zero ? srlos_pkg::ST_RESP : srlos_pkg::ST_READ;
               end
            end
         end
         srlos_pkg::ST_READ: begin
            cmd.rd_wall = 1'b1;
            axis_in     = 1'b0;
            state_in    = srlos_pkg::ST_AXIS;
         end
         srlos_pkg::ST_AXIS: begin
            if (status.delta_zero) begin
               if (!status.in_slab) begin
                  state_in = srlos_pkg::ST_NEXT;
               end else if (axis_ff) begin
                  cmd.set_hit = 1'b1;
                  state_in    = srlos_pkg::ST_RESP;
               end else begin
                  axis_in = 1'b1;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = srlos_pkg::ST_WAIT_LO;
            end
         end
         srlos_pkg::ST_WAIT_LO: begin
            if (status.div_done) begin
               cmd.save_t1   = 1'b1;
               cmd.edge_hi   = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = srlos_pkg::ST_WAIT_HI;
            end
         end
         srlos_pkg::ST_WAIT_HI: begin
            cmd.edge_hi = 1'b1;
            if (status.div_done) begin
               cmd.update = 1'b1;
               state_in   = srlos_pkg::ST_CHECK;
            end
         end
         srlos_pkg::ST_CHECK: begin
            if (!status.t_ok) begin
               state_in = srlos_pkg::ST_NEXT;
            end else if (axis_ff) begin
               cmd.set_hit = 1'b1;
               state_in    = srlos_pkg::ST_RESP;
            end else begin
               axis_in  = 1'b1;
               state_in = srlos_pkg::ST_AXIS;
            end
         end
         srlos_pkg::ST_NEXT: begin
            if (status.last) begin
               state_in = srlos_pkg::ST_RESP;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = srlos_pkg::ST_READ;
            end
         end
         srlos_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = srlos_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srlos_pkg::ST_IDLE;
         end
      endcase
   end

   // divider is only started while idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   // a quotient only arrives while one is awaited
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |->
         (state_ff == srlos_pkg::ST_WAIT_LO || state_ff == srlos_pkg::ST_WAIT_HI))
      else $error("unexpected divider result");

   // never step past the last wall in use
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cmd.inc_idx |-> !status.last)
      else $error("wall index stepped past the last wall");

   // a hit ends the walk with a response
   a_hit_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.set_hit |=> state_ff == srlos_pkg::ST_RESP)
      else $error("hit without response");

endmodule
`default_nettype wire

### tb/sv/tb_segment_rect_line_of_sight_core.sv
`timescale 1ns / 1ps
module tb_segment_rect_line_of_sight_core;

   localparam int T_BITS    = srlos_pkg::T_FRAC_BITS_DEF;
   localparam int WDOG_MAX  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [srlos_pkg::CSR_W-1:0] csr_wdata = '0;

   srlos_req_if req_chan();
   srlos_rsp_if rsp_chan();

   segment_rect_line_of_sight_core u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the wall table and the walls-in-use register
   srlos_pkg::wall_type wall_shadow [srlos_pkg::MAX_WALLS_DEF];
   int         walls_active;
   bit         clear_queue [$];
   int         error_count = 0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   int         idle_cycles = 0;

   // hold quiet inputs from time zero
   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode = srlos_pkg::MODE_WRITE;
      req_chan.wall_index = '0;
      req_chan.rect_x = '0;
      req_chan.rect_y = '0;
      req_chan.rect_w = '0;
      req_chan.rect_h = '0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.end_x = '0;
      req_chan.end_y = '0;
      rsp_chan.ready = 1'b0;
   end

   // one axis of the slab test; returns 0 on a miss
   function automatic bit slab_pass(longint lo, longint hi, longint s, longint e,
                                    ref longint tmin, ref longint tmax);
      longint delta, t1, t2, tmp;
      delta = e - s;
      if (delta == 0) return !(s < lo || s > hi);
      t1 = ((lo - s) * (longint'(1) << T_BITS)) / delta;
      t2 = ((hi - s) * (longint'(1) << T_BITS)) / delta;
      if (t1 > t2) begin
         tmp = t1; t1 = t2; t2 = tmp;
      end
      if (t1 > tmin) tmin = t1;
      if (t2 < tmax) tmax = t2;
      return tmin <= tmax;
   endfunction

   function automatic bit sight_clear(logic signed [15:0] sx, logic signed [15:0] sy,
                                      logic signed [15:0] ex, logic signed [15:0] ey);
      longint tmin, tmax;
      int n;
      srlos_pkg::wall_type w;
      n = (walls_active > srlos_pkg::MAX_WALLS_DEF) ? srlos_pkg::MAX_WALLS_DEF
                                                     : walls_active;
      for (int i = 0; i < n; i++) begin
         w = wall_shadow[i];
         tmin = 0;
         tmax = longint'(1) << T_BITS;
         if (slab_pass(w.x, longint'(w.x) + w.w, sx, ex, tmin, tmax) &&
             slab_pass(w.y, longint'(w.y) + w.h, sy, ey, tmin, tmax))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // drive one word and predict on acceptance; valid stays up for the next word
   task automatic send_word(logic mode, logic [3:0] idx, logic signed [15:0] rx,
                            logic signed [15:0] ry, logic [14:0] rw, logic [14:0] rh,
                            logic signed [15:0] sx, logic signed [15:0] sy,
                            logic signed [15:0] ex, logic signed [15:0] ey);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.wall_index <= idx;
      req_chan.rect_x <= rx;
      req_chan.rect_y <= ry;
      req_chan.rect_w <= rw;
      req_chan.rect_h <= rh;
      req_chan.start_x <= sx;
      req_chan.start_y <= sy;
      req_chan.end_x <= ex;
      req_chan.end_y <= ey;
      do @(posedge clock); while (!req_chan.ready);
      if (mode == srlos_pkg::MODE_WRITE) begin
         wall_shadow[idx] = '{x: rx, y: ry, w: rw, h: rh};
      end else begin
         clear_queue.insert(clear_queue.size(), sight_clear(sx, sy, ex, ey));
      end
   endtask

   task automatic send_wall(int idx, logic signed [15:0] rx, logic signed [15:0] ry,
                            logic [14:0] rw, logic [14:0] rh);
      send_word(srlos_pkg::MODE_WRITE, idx[3:0], rx, ry, rw, rh,
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic send_query(logic signed [15:0] sx, logic signed [15:0] sy,
                             logic signed [15:0] ex, logic signed [15:0] ey);
      send_word(srlos_pkg::MODE_QUERY, 4'($urandom), 16'($urandom), 16'($urandom),
                15'($urandom), 15'($urandom), sx, sy, ex, ey);
   endtask

   // drop valid, wait until idle, then load the register
   task automatic set_walls_active(int n);
      req_chan.valid <= 1'b0;
      while (clear_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= srlos_pkg::CSR_W'(n);
      @(posedge clock);
      csr_we <= 1'b0;
      walls_active = n;
   endtask

   // random receiver stalls
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // check each response word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (clear_queue.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual line_clear=%0b",
                     $time, rsp_chan.line_clear);
            error_count++;
         end else begin
            if (rsp_chan.line_clear !== clear_queue[0]) begin
               $display("%0t: line_clear mismatch, expected %0b, actual %0b",
                        $time, clear_queue[0], rsp_chan.line_clear);
               error_count++;
            end
            void'(clear_queue.pop_front());
         end
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic signed [15:0] near_coord();
      return 16'($signed($urandom_range(1600)) - 800);
   endfunction

   // directed: extremes of walls and segments
   task automatic test_directed();
      send_wall(0, -16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff);
      send_wall(1, 16'sd32767, 16'sd32767, 15'd0, 15'd0);
      send_wall(2, 16'sd0, 16'sd0, 15'd160, 15'd160);
      send_wall(3, -16'sd100, 16'sd50, 15'd0, 15'd300);
      send_wall(15, 16'sd200, -16'sd200, 15'd10, 15'd10);
      set_walls_active(0);
      send_query(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      set_walls_active(1);
      send_query(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      send_query(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_query(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
      set_walls_active(4);
      send_query(16'sd80, -16'sd500, 16'sd80, 16'sd500);   // vertical segment
      send_query(-16'sd500, 16'sd160, 16'sd500, 16'sd160); // grazing an edge
      send_query(16'sd161, 16'sd0, 16'sd400, 16'sd0);
      send_query(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767);
      send_wall(0, 16'sd1000, 16'sd1000, 15'd5, 15'd5);
      send_query(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767); // hits entry 1
      send_query(-16'sd100, 16'sd0, -16'sd100, 16'sd400);
      // index out of range cannot occur with a 4-bit index; saturate the count
      for (int i = 4; i < 16; i++) send_wall(i, near_coord(), near_coord(), 15'd8, 15'd8);
      set_walls_active(31);
      send_query(-16'sd800, -16'sd800, 16'sd800, 16'sd800);
      set_walls_active(16);
      send_query(16'sd201, -16'sd195, 16'sd201, -16'sd195);
   endtask

   // random: rewrite walls and query, mostly near the walls
   task automatic test_random(int count, int sp, int rp);
      int kind;
      sender_idle_pct = sp;
      receiver_stall_pct = rp;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         if (kind < 3)
            send_wall($urandom_range(15),
                      (kind == 0) ? 16'($urandom) : near_coord(),
                      (kind == 0) ? 16'($urandom) : near_coord(),
                      (kind == 0) ? 15'($urandom) : 15'($urandom_range(300)),
                      (kind == 0) ? 15'($urandom) : 15'($urandom_range(300)));
         else if (kind == 3)
            send_query(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_query(near_coord(), near_coord(),
                       ($urandom_range(5) == 0) ? near_coord() : near_coord(),
                       near_coord());
      end
      set_walls_active($urandom_range(16));
   endtask

   initial begin
      walls_active = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(230, 0, 0);
      test_random(230, 75, 0);
      test_random(230, 0, 75);
      set_walls_active(2);
      test_random(230, 25, 25);
      while (clear_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

### files.f
design/srlos_pkg.sv
design/srlos_if.sv
design/srlos_div.sv
design/srlos_datapath.sv
design/srlos_ctrl.sv
design/segment_rect_line_of_sight_core.sv
tb/sv/tb_segment_rect_line_of_sight_core.sv
